// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands, clocked on the rising edge and muted while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/cdt_pkg.sv -----
package cdt_pkg;

   localparam int DELTA_W  = 10;
   localparam int YEAR_W   = 16;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MILLIS_W = 10;

   localparam int MILLIS_MAX = 999;
   localparam int SECOND_MAX = 59;
   localparam int MINUTE_MAX = 59;
   localparam int HOUR_MAX   = 23;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 56;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_ADD  = 2'd1;
   localparam logic [1:0] CMD_SUB  = 2'd2;

   localparam logic [1:0] UNIT_MILLIS = 2'd0;
   localparam logic [1:0] UNIT_SECOND = 2'd1;
   localparam logic [1:0] UNIT_MINUTE = 2'd2;
   localparam logic [1:0] UNIT_HOUR   = 2'd3;

   localparam logic       CSR_YEAR_MIN = 1'b0;
   localparam logic       CSR_YEAR_MAX = 1'b1;

   localparam logic [YEAR_W-1:0]  YEAR_MIN_RST = 16'd2000;
   localparam logic [YEAR_W-1:0]  YEAR_MAX_RST = 16'd2099;
   localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

   // y % 25 == 0  <=>  (y * 25^-1 mod 2^16) <= (2^16 - 1) / 25
   localparam logic [YEAR_W-1:0] DIV25_INV   = 16'd23593;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

   typedef struct packed {
      logic accept;
      logic load;
      logic add;
      logic sub;
   } step_type;

   function automatic logic [DELTA_W-1:0] sat_delta(input logic [1:0] unit,
                                                    input logic [DELTA_W-1:0] delta);
      logic [DELTA_W-1:0] limit;
      case (unit)
         UNIT_MILLIS: limit = DELTA_W'(MILLIS_MAX + 1);
         UNIT_SECOND: limit = DELTA_W'(SECOND_MAX + 1);
         UNIT_MINUTE: limit = DELTA_W'(MINUTE_MAX + 1);
         default:     limit = DELTA_W'(HOUR_MAX + 1);
      endcase
      return (delta > limit) ? limit : delta;
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] prod;
      logic              div25;
      prod  = year * DIV25_INV;
      div25 = (prod <= DIV25_LIMIT);
      return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
   endfunction

   // Months 0 and 13..15 count as 31 days
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month) inside
         4'd2:                    days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
         default:                 days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ----- rtl/core/cdt_time_cell.sv -----
module cdt_time_cell #(
   parameter int FIELD_W   = cdt_pkg::MILLIS_W,
   parameter int FIELD_MAX = cdt_pkg::MILLIS_MAX
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cdt_pkg::step_type            step,
   input  logic                         start,
   input  logic [cdt_pkg::DELTA_W-1:0]  amount,
   input  logic [FIELD_W-1:0]           load_value,
   input  logic                         carry_in,
   output logic                         carry_out,
   output logic [FIELD_W-1:0]           value
);

   localparam int SUM_W = ((FIELD_W > cdt_pkg::DELTA_W) ? FIELD_W : cdt_pkg::DELTA_W) + 1;

   logic [FIELD_W-1:0]          value_ff, value_in;
   logic                        active;
   logic [cdt_pkg::DELTA_W-1:0] amt;
   logic [SUM_W-1:0]            cur, amt_x, sum;
   logic                        over, under;

   assign active = start | carry_in;
   assign amt    = start ? amount : cdt_pkg::DELTA_W'(1);
   assign cur    = SUM_W'(value_ff);
   assign amt_x  = SUM_W'(amt);
   assign sum    = cur + amt_x;
   assign over   = (sum > SUM_W'(FIELD_MAX));
   assign under  = (cur < amt_x);

   assign carry_out = active & ((step.add & over) | (step.sub & under));

   always_comb begin
      value_in = value_ff;
      if (step.load) begin
         value_in = load_value;
      end else if (active && step.add) begin
         value_in = over ? '0 : FIELD_W'(sum);
      end else if (active && step.sub) begin
         value_in = under ? FIELD_W'(FIELD_MAX) : FIELD_W'(cur - amt_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ----- rtl/core/cdt_cal_cell.sv -----
module cdt_cal_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  cdt_pkg::step_type            step,
   input  logic                         carry_in,
   input  logic [cdt_pkg::YEAR_W-1:0]   year_min,
   input  logic [cdt_pkg::YEAR_W-1:0]   year_max,
   input  logic [cdt_pkg::YEAR_W-1:0]   load_year,
   input  logic [cdt_pkg::MONTH_W-1:0]  load_month,
   input  logic [cdt_pkg::DAY_W-1:0]    load_day,
   output logic [cdt_pkg::YEAR_W-1:0]   year,
   output logic [cdt_pkg::MONTH_W-1:0]  month,
   output logic [cdt_pkg::DAY_W-1:0]    day,
   output logic                         wrapped
);

   logic [cdt_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [cdt_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cdt_pkg::DAY_W-1:0]   day_ff, day_in;
   logic                        wrapped_ff, wrapped_in;
   logic                        leap, wrap_now;
   logic [cdt_pkg::DAY_W-1:0]   dim;
   logic [cdt_pkg::DAY_W:0]     day_inc;

   assign leap    = cdt_pkg::is_leap(year_ff);
   assign dim     = cdt_pkg::month_days(month_ff, leap);
   assign day_inc = {1'b0, day_ff} + (cdt_pkg::DAY_W + 1)'(1);

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      wrap_now = 1'b0;
      if (step.load) begin
         year_in  = load_year;
         month_in = load_month;
         day_in   = load_day;
      end else if (carry_in && step.add) begin
         if (day_inc <= {1'b0, dim}) begin
            day_in = day_inc[cdt_pkg::DAY_W-1:0];
         end else begin
            day_in = cdt_pkg::DAY_W'(1);
            if (month_ff < cdt_pkg::MONTH_DEC) begin
               month_in = month_ff + cdt_pkg::MONTH_W'(1);
            end else begin
               month_in = cdt_pkg::MONTH_W'(1);
               if (year_ff < year_max) begin
                  year_in = year_ff + cdt_pkg::YEAR_W'(1);
               end else begin
                  year_in  = year_min;
                  wrap_now = 1'b1;
               end
            end
         end
      end else if (carry_in && step.sub) begin
         if (day_ff >= cdt_pkg::DAY_W'(2)) begin
            day_in = day_ff - cdt_pkg::DAY_W'(1);
         end else if (month_ff >= cdt_pkg::MONTH_W'(2)) begin
            month_in = month_ff - cdt_pkg::MONTH_W'(1);
            day_in   = cdt_pkg::month_days(month_ff - cdt_pkg::MONTH_W'(1), leap);
         end else begin
            month_in = cdt_pkg::MONTH_DEC;
            day_in   = cdt_pkg::month_days(cdt_pkg::MONTH_DEC, leap);
            if (year_ff > year_min) begin
               year_in = year_ff - cdt_pkg::YEAR_W'(1);
            end else begin
               year_in  = year_max;
               wrap_now = 1'b1;
            end
         end
      end
   end

   assign wrapped_in = step.accept ? wrap_now : wrapped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff    <= cdt_pkg::YEAR_MIN_RST;
         month_ff   <= cdt_pkg::MONTH_W'(1);
         day_ff     <= cdt_pkg::DAY_W'(1);
         wrapped_ff <= 1'b0;
      end else begin
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign year    = year_ff;
   assign month   = month_ff;
   assign day     = day_ff;
   assign wrapped = wrapped_ff;

endmodule

// ----- rtl/core/calendar_datetime_stepper.sv -----
// Latency: a word accepted at one edge shows its result from the next cycle on.
// Throughput: one word per cycle if no result waits on rsp_tready; the millis,
// second, minute, hour and calendar cells settle carries in the accepting cycle.
// Reset (synchronous, active high): 2000-01-01 00:00:00.000, year_min 2000,
// year_max 2099, no result pending; usable from the first cycle after reset.
module calendar_datetime_stepper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // delta, load_year, load_month, load_day, load_hour, load_minute,
   // load_second, load_millis, zero pad
   input  logic [cdt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command, unit
   input  logic [cdt_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // year_out, month_out, day_out, hour_out, minute_out, second_out,
   // millis_out, zero pad
   output logic [cdt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // year_wrapped
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [cdt_pkg::YEAR_W-1:0]      csr_wdata
);

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cdt_pkg::YEAR_W-1:0]     year_min_ff, year_max_ff;
   logic                           accept;
   logic [1:0]                     command, unit;
   logic [cdt_pkg::DELTA_W-1:0]    delta, amount;
   cdt_pkg::step_type              step;
   logic [3:0]                     start;
   logic [4:0]                     carry;

   logic [cdt_pkg::MILLIS_W-1:0]   millis;
   logic [cdt_pkg::SECOND_W-1:0]   second;
   logic [cdt_pkg::MINUTE_W-1:0]   minute;
   logic [cdt_pkg::HOUR_W-1:0]     hour;
   logic [cdt_pkg::DAY_W-1:0]      day;
   logic [cdt_pkg::MONTH_W-1:0]    month;
   logic [cdt_pkg::YEAR_W-1:0]     year;
   logic                           wrapped;

   assign command = req_tuser[1:0];
   assign unit    = req_tuser[3:2];
   assign delta   = req_tdata[9:0];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign step.accept = accept;
   assign step.load   = accept && (command == cdt_pkg::CMD_LOAD);
   assign step.add    = accept && (command == cdt_pkg::CMD_ADD);
   assign step.sub    = accept && (command == cdt_pkg::CMD_SUB);

   assign amount   = cdt_pkg::sat_delta(unit, delta);
   assign start[0] = (unit == cdt_pkg::UNIT_MILLIS);
   assign start[1] = (unit == cdt_pkg::UNIT_SECOND);
   assign start[2] = (unit == cdt_pkg::UNIT_MINUTE);
   assign start[3] = (unit == cdt_pkg::UNIT_HOUR);
   assign carry[0] = 1'b0;

   cdt_time_cell #(
      .FIELD_W   (cdt_pkg::MILLIS_W),
      .FIELD_MAX (cdt_pkg::MILLIS_MAX)
   ) u_millis (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start      (start[0]),
      .amount     (amount),
      .load_value (req_tdata[61:52]),
      .carry_in   (carry[0]),
      .carry_out  (carry[1]),
      .value      (millis)
   );

   cdt_time_cell #(
      .FIELD_W   (cdt_pkg::SECOND_W),
      .FIELD_MAX (cdt_pkg::SECOND_MAX)
   ) u_second (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start      (start[1]),
      .amount     (amount),
      .load_value (req_tdata[51:46]),
      .carry_in   (carry[1]),
      .carry_out  (carry[2]),
      .value      (second)
   );

   cdt_time_cell #(
      .FIELD_W   (cdt_pkg::MINUTE_W),
      .FIELD_MAX (cdt_pkg::MINUTE_MAX)
   ) u_minute (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start      (start[2]),
      .amount     (amount),
      .load_value (req_tdata[45:40]),
      .carry_in   (carry[2]),
      .carry_out  (carry[3]),
      .value      (minute)
   );

   cdt_time_cell #(
      .FIELD_W   (cdt_pkg::HOUR_W),
      .FIELD_MAX (cdt_pkg::HOUR_MAX)
   ) u_hour (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start      (start[3]),
      .amount     (amount),
      .load_value (req_tdata[39:35]),
      .carry_in   (carry[3]),
      .carry_out  (carry[4]),
      .value      (hour)
   );

   cdt_cal_cell u_cal (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .carry_in   (carry[4]),
      .year_min   (year_min_ff),
      .year_max   (year_max_ff),
      .load_year  (req_tdata[25:10]),
      .load_month (req_tdata[29:26]),
      .load_day   (req_tdata[34:30]),
      .year       (year),
      .month      (month),
      .day        (day),
      .wrapped    (wrapped)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_min_ff <= cdt_pkg::YEAR_MIN_RST;
         year_max_ff <= cdt_pkg::YEAR_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cdt_pkg::CSR_YEAR_MIN: year_min_ff <= csr_wdata;
            cdt_pkg::CSR_YEAR_MAX: year_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state registers double as the output word; they only move on accept
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, millis, second, minute, hour, day, month, year};
   assign rsp_tuser  = wrapped;

endmodule

// ----- rtl/core/cdt_checker.sv -----
`include "assert_macros.svh"

module cdt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cdt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser
);

   logic req_acc;

   assign req_acc = req_tvalid && req_tready;

   `ASSERT_NEXT(a_acc_gives_rsp, clock, reset, req_acc, rsp_tvalid)
   `ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   `ASSERT_NOW(a_no_take_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind calendar_datetime_stepper cdt_checker u_cdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
